/* src/fake_cia_timer_with_random_reads_core_assert.svh */
// Assertion macros shared by the timer core RTL.
`ifndef FAKE_CIA_TIMER_WITH_RANDOM_READS_CORE_ASSERT_SVH
`define FAKE_CIA_TIMER_WITH_RANDOM_READS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/fctimer_pkg.sv */
// Package: shared types and constants of the timer core.
`default_nettype none
package fctimer_pkg;

	// Item kinds
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_LOCK_TIMER  = 2'd0,
		CFG_RESET_COUNT = 2'd1,
		CFG_RANDOM_SEED = 2'd2
	} cfg_idx_t;

	localparam logic [7:0]  ADDR_TIMER_LO   = 8'h04;
	localparam logic [7:0]  ADDR_TIMER_HI   = 8'h05;
	localparam logic [7:0]  ADDR_CONTROL    = 8'h0e;
	localparam int unsigned CTRL_START_BIT  = 0;
	localparam int unsigned CTRL_FORCE_BIT  = 4;
	localparam logic [7:0]  CTRL_FORCE_MASK = 8'h10;
	localparam logic [15:0] LCG_MUL         = 16'd13;
	localparam logic [15:0] LCG_INC         = 16'd1;
	localparam logic [15:0] RESET_COUNT_DEF = 16'hffff;
	localparam logic [15:0] RANDOM_SEED_DEF = 16'h0000;

	// One item on its way from the input stage into the state
	typedef struct packed {
		logic       fire;
		cmd_t       cmd;
		logic [7:0] addr;
		logic [7:0] data;
	} op_t;

	// One configuration write
	typedef struct packed {
		logic        fire;
		logic [1:0]  index;
		logic [15:0] value;
	} cfg_t;

endpackage
`default_nettype wire

/* src/fctimer_timer.sv */
// Timer A: down counter, reload latch, control byte and arm flag.
`default_nettype none
`include "fake_cia_timer_with_random_reads_core_assert.svh"
module fctimer_timer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fctimer_pkg::op_t   op,
	input  wire fctimer_pkg::cfg_t  cfg,
	output logic                    irq
);

	logic        lock_q;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] latch_q, latch_d;
	logic [7:0]  ctrl_q, ctrl_d;
	logic        armed_q, armed_d;
	logic [15:0] latch_hi;

	// Latch with the written byte ORed into its high half
	assign latch_hi = latch_q | {op.data, 8'h00};

	// Next timer state for the item being retired
	always_comb begin
		cnt_d   = cnt_q;
		latch_d = latch_q;
		ctrl_d  = ctrl_q;
		armed_d = armed_q;
		irq     = 1'b0;
		if (cfg.fire && cfg.index == fctimer_pkg::CFG_RESET_COUNT) begin
			cnt_d   = cfg.value;
			latch_d = cfg.value;
		end else if (op.fire) begin
			unique case (op.cmd)
				fctimer_pkg::CMD_TICK: begin
					if (armed_q && cnt_q == 16'h0000) begin
						cnt_d = latch_q;
						irq   = 1'b1;
					end else begin
						cnt_d = cnt_q - 16'd1;
					end
				end
				fctimer_pkg::CMD_WRITE: begin
					if (!lock_q) begin
						case (op.addr)
							fctimer_pkg::ADDR_TIMER_LO: begin
								latch_d = {8'h00, op.data};
							end
							fctimer_pkg::ADDR_TIMER_HI: begin
								latch_d = latch_hi;
								if (ctrl_q[fctimer_pkg::CTRL_START_BIT])
									cnt_d = latch_hi;
							end
							fctimer_pkg::ADDR_CONTROL: begin
								// force load is a strobe, never kept in the control byte
								ctrl_d = op.data & ~fctimer_pkg::CTRL_FORCE_MASK;
								if (op.data[fctimer_pkg::CTRL_FORCE_BIT])
									cnt_d = latch_q;
								armed_d = 1'b1;
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// Timer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q  <= 1'b0;
			cnt_q   <= fctimer_pkg::RESET_COUNT_DEF;
			latch_q <= fctimer_pkg::RESET_COUNT_DEF;
			ctrl_q  <= 8'h00;
			armed_q <= 1'b0;
		end else begin
			if (cfg.fire && cfg.index == fctimer_pkg::CFG_LOCK_TIMER)
				lock_q <= cfg.value[0];
			cnt_q   <= cnt_d;
			latch_q <= latch_d;
			ctrl_q  <= ctrl_d;
			armed_q <= armed_d;
		end
	end

	`FCT_ASSERT_NOW(a_irq_needs_arm, !armed_q, !irq, "irq from an unarmed timer")
	`FCT_ASSERT_NOW(a_force_cleared, 1'b1, !ctrl_q[fctimer_pkg::CTRL_FORCE_BIT],
		"force load bit kept in control byte")

endmodule
`default_nettype wire

/* src/fctimer_regs.sv */
// Register file and pseudo-random read generator.
`default_nettype none
module fctimer_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fctimer_pkg::op_t   op,
	input  wire fctimer_pkg::cfg_t  cfg,
	output logic [7:0]              read_data
);

	logic [7:0]  rf_q [16];
	logic [15:0] rnd_q;
	logic [15:0] rnd_next;
	logic        in_range;
	logic        is_rnd_addr;
	logic        do_read;

	assign in_range    = (op.addr[7:4] == 4'h0);
	assign is_rnd_addr = (op.addr == fctimer_pkg::ADDR_TIMER_LO) ||
		(op.addr == fctimer_pkg::ADDR_TIMER_HI);
	assign do_read     = op.fire && op.cmd == fctimer_pkg::CMD_READ;
	assign rnd_next    = rnd_q * fctimer_pkg::LCG_MUL + fctimer_pkg::LCG_INC;

	// Read data: generator bits at timer addresses, else the stored byte; zero unless in-range read
	always_comb begin
		read_data = 8'h00;
		if (do_read && in_range) begin
			if (is_rnd_addr)
				read_data = {3'b000, rnd_next[7:3]};
			else
				read_data = rf_q[op.addr[3:0]];
		end
	end

	// Stored bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				rf_q[i] <= 8'h00;
		end else if (op.fire && op.cmd == fctimer_pkg::CMD_WRITE && in_range) begin
			rf_q[op.addr[3:0]] <= op.data;
		end
	end

	// Generator word: seeded by configuration, stepped by timer-address reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= fctimer_pkg::RANDOM_SEED_DEF;
		end else if (cfg.fire && cfg.index == fctimer_pkg::CFG_RANDOM_SEED) begin
			rnd_q <= cfg.value;
		end else if (do_read && in_range && is_rnd_addr) begin
			rnd_q <= rnd_next;
		end
	end

endmodule
`default_nettype wire

/* src/fake_cia_timer_with_random_reads_core.sv */
// Top level: input stage, timer and register file, result register.
// The core takes one item (tick, register read or register write) per clock and
// returns one result for each. An item is captured in the input stage; when it
// retires, it updates the timer and register state and its result is loaded into
// the output register, from which the result is presented until it is taken. One
// item a cycle is sustained as long as results are taken; a held result stalls the
// input stage. The configuration port is always ready and is meant to be written
// only while no item is in flight.
`default_nettype none
`include "fake_cia_timer_with_random_reads_core_assert.svh"
module fake_cia_timer_with_random_reads_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] addr, [15:8] data
	input  wire logic [1:0]  s_tuser,   // [1:0] cmd
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] read_data, [8] irq_pulse, [15:9] zero
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic                valid_s1;
	fctimer_pkg::cmd_t   cmd_s1;
	logic [7:0]          addr_s1;
	logic [7:0]          data_s1;
	logic                advance;
	logic                out_valid_q;
	logic [7:0]          rdata_q;
	logic                irq_q;
	logic [7:0]          rdata;
	logic                irq;
	fctimer_pkg::op_t    op;
	fctimer_pkg::cfg_t   cfg;

	// Item retires when the result register is free or being drained
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign op.fire  = advance;
	assign op.cmd   = cmd_s1;
	assign op.addr  = addr_s1;
	assign op.data  = data_s1;

	assign cfg.fire  = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.value = cfg_data;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= fctimer_pkg::cmd_t'(s_tuser);
			addr_s1 <= s_tdata[7:0];
			data_s1 <= s_tdata[15:8];
		end
	end

	fctimer_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.cfg    (cfg),
		.irq    (irq)
	);

	fctimer_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cfg       (cfg),
		.read_data (rdata)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rdata_q <= rdata;
			irq_q   <= irq;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0000000, irq_q, rdata_q};

	`FCT_ASSERT_NOW(a_irq_no_data, m_tvalid && m_tdata[8], m_tdata[7:0] == 8'h00,
		"irq result carries read data")
	`FCT_ASSERT_NOW(a_stall_blocks, valid_s1 && m_tvalid && !m_tready, !s_tready,
		"input taken while result held and stage full")
	`FCT_ASSERT_NEXT(a_retire_shows, advance, m_tvalid, "retired item left no result")

endmodule
`default_nettype wire
